@@ design/tmexu_pkg.sv @@
package tmexu_pkg;

    localparam int TAPE_CELLS_DEFAULT = 32768;

    localparam int OP_W       = 3;
    localparam int COUNT_W    = 16;
    localparam int INDEX_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int ERR_W      = 2;
    localparam int DPTR_W     = 15;
    localparam int LIMIT_W    = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // wide enough for pointer + count and for a tape depth of 65536
    localparam int EXT_W = 17;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd30000;
    localparam logic [BYTE_W-1:0]  EOI_RESET   = 8'd0;

    localparam logic [CFG_INDEX_W-1:0] CFG_POINTER_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EOI_VALUE     = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_FWD        = 3'd0,
        OP_BACK       = 3'd1,
        OP_ADD        = 3'd2,
        OP_SUB        = 3'd3,
        OP_WRITE      = 3'd4,
        OP_READ       = 3'd5,
        OP_LOOP_START = 3'd6,
        OP_LOOP_END   = 3'd7
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_BELOW_ZERO = 2'd1,
        ERR_LIMIT      = 2'd2
    } err_t;

    typedef struct packed {
        logic [INDEX_W-1:0] next_index;
        err_t               error_code;
        logic [BYTE_W-1:0]  emit_byte;
        logic [COUNT_W-1:0] emit_repeat;
        logic [DPTR_W-1:0]  data_pointer;
        logic [BYTE_W-1:0]  cell_value;
    } result_t;

endpackage

@@ design/tmexu_if.sv @@
interface tmexu_in_if import tmexu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [COUNT_W-1:0] count;
    logic [INDEX_W-1:0] jump_target;
    logic [BYTE_W-1:0]  read_value;
    logic               read_at_end;

    modport source (output valid, output op, output count, output jump_target,
                    output read_value, output read_at_end, input ready);
    modport sink   (input valid, input op, input count, input jump_target,
                    input read_value, input read_at_end, output ready);
endinterface

interface tmexu_out_if import tmexu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] next_index;
    logic [ERR_W-1:0]   error_code;
    logic [BYTE_W-1:0]  emit_byte;
    logic [COUNT_W-1:0] emit_repeat;
    logic [DPTR_W-1:0]  data_pointer;
    logic [BYTE_W-1:0]  cell_value;

    modport source (output valid, output next_index, output error_code, output emit_byte,
                    output emit_repeat, output data_pointer, output cell_value,
                    input ready);
    modport sink   (input valid, input next_index, input error_code, input emit_byte,
                    input emit_repeat, input data_pointer, input cell_value,
                    output ready);
endinterface

@@ design/tape_machine_execute_unit.sv @@
// A result word enters the result buffer when its instruction is accepted; a pointer move
// that passes its check pushes its word after the registered tape read at the new cell.
// Throughput: one instruction per cycle while the result buffer has room; a pointer move
// that passes stalls input for its tape read. A two-word result buffer decouples output.
// Reset: pointer, index and limits reset at once; the tape is then zeroed by a sweep of
// TAPE_CELLS cells (32768 by default) with instr.ready low. Config writes are always taken.
module tape_machine_execute_unit import tmexu_pkg::*;
#(
    parameter int TAPE_CELLS = TAPE_CELLS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    tmexu_in_if.sink               instr,
    tmexu_out_if.source            result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int               PTR_W     = $clog2(TAPE_CELLS);
    localparam logic [EXT_W-1:0] CELLS_EXT = EXT_W'(TAPE_CELLS);
    localparam logic [PTR_W-1:0] LAST_CELL = PTR_W'(TAPE_CELLS - 1);

    logic [BYTE_W-1:0]  tape [TAPE_CELLS];

    logic [LIMIT_W-1:0] limit_reg;
    logic [BYTE_W-1:0]  eoi_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   ptr_next;
    logic [INDEX_W-1:0] index_reg;
    logic [INDEX_W-1:0] index_next;
    logic [BYTE_W-1:0]  cell_reg;
    logic [BYTE_W-1:0]  cell_next;
    logic               clr_busy_reg;
    logic [PTR_W-1:0]   clr_addr_reg;
    logic               move_pend_reg;
    logic [BYTE_W-1:0]  rd_data_reg;

    op_t                op;
    err_t               err;
    logic               accept;
    logic               is_move;
    logic               cell_we;
    logic [BYTE_W-1:0]  ebyte;
    logic [COUNT_W-1:0] erep;
    logic [EXT_W-1:0]   ptr_ext;
    logic [EXT_W-1:0]   count_ext;
    logic [EXT_W-1:0]   lim_ext;
    logic [EXT_W-1:0]   fwd_sum;
    logic [EXT_W-1:0]   back_diff;
    logic [EXT_W-1:0]   ptr_next_ext;
    logic [INDEX_W-1:0] index_inc;

    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    logic [BYTE_W-1:0]  mem_wdata;

    result_t            res_now;
    result_t            res_move;
    logic               buf_push;
    result_t            buf_push_data;
    logic               buf_pop;
    logic               buf_valid;
    result_t            buf_data;
    logic               buf_full;

    assign instr.ready = !clr_busy_reg && !move_pend_reg && !buf_full;
    assign accept      = instr.valid && instr.ready;
    assign op          = op_t'(instr.op);

    assign ptr_ext   = EXT_W'(ptr_reg);
    assign count_ext = EXT_W'(instr.count);
    assign lim_ext   = (EXT_W'(limit_reg) > CELLS_EXT) ? CELLS_EXT : EXT_W'(limit_reg);
    assign fwd_sum   = ptr_ext + count_ext;
    assign back_diff = ptr_ext - count_ext;
    assign index_inc = index_reg + INDEX_W'(1);

    always_comb
    begin
        err        = ERR_NONE;
        index_next = index_inc;
        ptr_next   = ptr_reg;
        cell_next  = cell_reg;
        cell_we    = 1'b0;
        is_move    = 1'b0;
        ebyte      = '0;
        erep       = '0;
        case (op)
            OP_FWD:
            begin
                if (fwd_sum >= lim_ext)
                begin
                    err = ERR_LIMIT;
                end
                else
                begin
                    ptr_next = fwd_sum[PTR_W-1:0];
                    is_move  = 1'b1;
                end
            end
            OP_BACK:
            begin
                if (count_ext > ptr_ext)
                begin
                    err = ERR_BELOW_ZERO;
                end
                else
                begin
                    ptr_next = back_diff[PTR_W-1:0];
                    is_move  = 1'b1;
                end
            end
            OP_ADD:
            begin
                cell_next = cell_reg + instr.count[BYTE_W-1:0];
                cell_we   = 1'b1;
            end
            OP_SUB:
            begin
                cell_next = cell_reg - instr.count[BYTE_W-1:0];
                cell_we   = 1'b1;
            end
            OP_WRITE:
            begin
                ebyte = cell_reg;
                erep  = instr.count;
            end
            OP_READ:
            begin
                if (instr.count != '0)
                begin
                    cell_next = instr.read_at_end ? eoi_reg : instr.read_value;
                    cell_we   = 1'b1;
                end
            end
            OP_LOOP_START:
            begin
                if (cell_reg == '0)
                begin
                    index_next = instr.jump_target;
                end
            end
            OP_LOOP_END:
            begin
                if (cell_reg != '0)
                begin
                    index_next = instr.jump_target;
                end
            end
            default:
            begin
                err = ERR_NONE;
            end
        endcase
        // a failed check leaves all state as it was
        if (err != ERR_NONE)
        begin
            index_next = index_reg;
        end
    end

    assign ptr_next_ext = EXT_W'(ptr_next);

    always_comb
    begin
        res_now.next_index   = index_next;
        res_now.error_code   = err;
        res_now.emit_byte    = ebyte;
        res_now.emit_repeat  = erep;
        res_now.data_pointer = ptr_next_ext[DPTR_W-1:0];
        res_now.cell_value   = cell_next;

        // pending move: state already updated, cell comes from the tape read
        res_move.next_index   = index_reg;
        res_move.error_code   = ERR_NONE;
        res_move.emit_byte    = '0;
        res_move.emit_repeat  = '0;
        res_move.data_pointer = ptr_ext[DPTR_W-1:0];
        res_move.cell_value   = rd_data_reg;
    end

    assign buf_push      = (accept && !is_move) || move_pend_reg;
    assign buf_push_data = move_pend_reg ? res_move : res_now;
    assign buf_pop       = result.valid && result.ready;

    assign mem_we    = clr_busy_reg || (accept && cell_we);
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : ptr_reg;
    assign mem_wdata = clr_busy_reg ? '0 : cell_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            eoi_reg       <= EOI_RESET;
            ptr_reg       <= '0;
            index_reg     <= '0;
            cell_reg      <= '0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            move_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_POINTER_LIMIT)
                begin
                    limit_reg <= cfg_data[LIMIT_W-1:0];
                end
                else if (cfg_index == CFG_EOI_VALUE)
                begin
                    eoi_reg <= cfg_data[BYTE_W-1:0];
                end
            end

            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + PTR_W'(1);
                if (clr_addr_reg == LAST_CELL)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end

            if (move_pend_reg)
            begin
                cell_reg      <= rd_data_reg;
                move_pend_reg <= 1'b0;
            end
            else if (accept)
            begin
                ptr_reg       <= ptr_next;
                index_reg     <= index_next;
                cell_reg      <= cell_next;
                move_pend_reg <= is_move;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tape[mem_waddr] <= mem_wdata;
        end
        if (accept && is_move)
        begin
            rd_data_reg <= tape[ptr_next];
        end
    end

    tmexu_res_buf u_res_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (buf_push),
        .push_data (buf_push_data),
        .pop       (buf_pop),
        .valid     (buf_valid),
        .data      (buf_data),
        .full      (buf_full)
    );

    assign result.valid        = buf_valid;
    assign result.next_index   = buf_data.next_index;
    assign result.error_code   = buf_data.error_code;
    assign result.emit_byte    = buf_data.emit_byte;
    assign result.emit_repeat  = buf_data.emit_repeat;
    assign result.data_pointer = buf_data.data_pointer;
    assign result.cell_value   = buf_data.cell_value;

endmodule

@@ design/tmexu_res_buf.sv @@
module tmexu_res_buf import tmexu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    valid,
    output result_t data,
    output logic    full
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] level_reg;
    logic [1:0] level_next;

    assign valid = (level_reg != 2'd0);
    assign full  = (level_reg == 2'd2);
    assign data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/tmexu_checker.sv @@
module tmexu_checker import tmexu_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               instr_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic [INDEX_W-1:0] result_next_index,
    input logic [ERR_W-1:0]   result_error_code,
    input logic [BYTE_W-1:0]  result_emit_byte,
    input logic [COUNT_W-1:0] result_emit_repeat,
    input logic [BYTE_W-1:0]  result_cell_value
);

    // tape sweep runs right after reset: no input taken, nothing to deliver
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !instr_ready && !result_valid)
        else $error("input ready or result valid at start of tape clear");

    a_clear_holds: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |=> !instr_ready)
        else $error("input ready one cycle into tape clear");

    a_err_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_error_code != ERR_NONE)
            |-> (result_emit_repeat == '0) && (result_emit_byte == '0))
        else $error("failed pointer move reports emitted output");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready
            |=> result_valid && $stable(result_next_index) && $stable(result_cell_value))
        else $error("stalled result word changed");

endmodule

bind tape_machine_execute_unit tmexu_checker u_tmexu_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .instr_ready        (instr.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_next_index  (result.next_index),
    .result_error_code  (result.error_code),
    .result_emit_byte   (result.emit_byte),
    .result_emit_repeat (result.emit_repeat),
    .result_cell_value  (result.cell_value)
);
